>>> rtl/cubic_bezier_point_generator_top_macros.svh
// Assertion macros for the cubic Bezier point generator.
`ifndef CUBIC_BEZIER_POINT_GENERATOR_TOP_MACROS_SVH
`define CUBIC_BEZIER_POINT_GENERATOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every clock outside reset.
`define CBZ_ASSERT_IMPL(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("cbz: same-cycle check failed");
// Next-cycle implication, checked on every clock outside reset.
`define CBZ_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("cbz: next-cycle check failed");
`else
`define CBZ_ASSERT_IMPL(label, clk_s, rst_s, ante, cons)
`define CBZ_ASSERT_NEXT(label, clk_s, rst_s, ante, cons)
`endif
`endif

>>> rtl/cbz_pkg.sv
// Shared types and constants of the cubic Bezier point generator.
package cbz_pkg;
  localparam int COORD_W   = 24;
  localparam int T_W       = 17;
  localparam int WEIGHT_W  = 49;
  localparam int CNT_W     = 7;
  localparam int DEF_MAX_POINTS = 64;
  localparam logic [CNT_W-1:0] PPS_RESET = 7'd32;
  localparam logic [T_W-1:0] T_ONE = 17'h10000;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [T_W-1:0] tval_t;
  typedef logic [WEIGHT_W-1:0] weight_t;

  // Control points of one segment, one axis at a time, index 0 = P0.
  typedef struct packed {
    coord_t [3:0] x;
    coord_t [3:0] y;
  } quad_t;

  // Point request from the sequencer.
  typedef struct packed {
    logic  valid;
    logic  last;
    tval_t t;
    quad_t quad;
  } point_req_t;

  // Sequencer status for the top level.
  typedef struct packed {
    logic busy;
    logic last;
  } seq_status_t;
endpackage

>>> rtl/cbz_seq.sv
// Segment sequencer: holds one quad and steps t over its points.
module cbz_seq import cbz_pkg::*; #(
  parameter int MAX_POINTS = DEF_MAX_POINTS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wen,
  input  logic [CNT_W-1:0] cfg_wdata,
  input  logic             load,
  input  quad_t            quad_in,
  input  logic             en,
  output point_req_t       req,
  output seq_status_t      status
);
  localparam int SW = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;

  // Long division of 65536 by a step count, returned as {quotient, remainder}
  function automatic logic [2*T_W-1:0] div_one(int s);
    logic [T_W-1:0] quo;
    logic [T_W-1:0] rem;
    quo = '0;
    rem = '0;
    for (int b = T_W-1; b >= 0; b--) begin
      rem = {rem[T_W-2:0], T_ONE[b]};
      if (rem >= T_W'(s)) begin
        rem    = rem - T_W'(s);
        quo[b] = 1'b1;
      end
    end
    return {quo, rem};
  endfunction

  function automatic logic [MAX_POINTS-1:0][T_W-1:0] make_q();
    logic [MAX_POINTS-1:0][T_W-1:0] tab;
    logic [2*T_W-1:0]               qr;
    tab = '0;
    for (int s = 1; s < MAX_POINTS; s++) begin
      qr     = div_one(s);
      tab[s] = qr[2*T_W-1:T_W];
    end
    return tab;
  endfunction

  function automatic logic [MAX_POINTS-1:0][T_W-1:0] make_r();
    logic [MAX_POINTS-1:0][T_W-1:0] tab;
    logic [2*T_W-1:0]               qr;
    tab = '0;
    for (int s = 1; s < MAX_POINTS; s++) begin
      qr     = div_one(s);
      tab[s] = qr[T_W-1:0];
    end
    return tab;
  endfunction

  localparam logic [MAX_POINTS-1:0][T_W-1:0] STEP_Q = make_q();
  localparam logic [MAX_POINTS-1:0][T_W-1:0] STEP_R = make_r();

  logic [CNT_W-1:0] pps;
  logic [CNT_W-1:0] n_eff;
  logic [SW-1:0]    span_next;
  logic             busy;
  logic [SW-1:0]    idx;
  logic [SW-1:0]    span;
  tval_t            q;
  logic [SW-1:0]    r;
  tval_t            sq;
  logic [SW-1:0]    sr;
  quad_t            quad;
  logic             last;
  logic [SW:0]      r_sum;
  logic             carry;

  // Clamp the configured count into range
  always_comb begin
    if (pps < 7'd2) n_eff = 7'd2;
    else if (pps > CNT_W'(MAX_POINTS)) n_eff = CNT_W'(MAX_POINTS);
    else n_eff = pps;
    span_next = SW'(n_eff - 7'd1);
  end

  assign last  = (idx == span);
  assign r_sum = {1'b0, r} + {1'b0, sr};
  assign carry = (r_sum >= {1'b0, span});

  // Hold configuration
  always_ff @(posedge clk) begin
    if (rst) pps <= PPS_RESET;
    else if (cfg_wen) pps <= cfg_wdata;
  end

  // Advance t by the quotient and remainder of 65536 / span
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= '0;
      span <= span_next;
      q    <= '0;
      r    <= '0;
      sq   <= STEP_Q[span_next];
      sr   <= SW'(STEP_R[span_next]);
      quad <= quad_in;
    end else if (en && busy) begin
      if (last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 1'b1;
        q   <= q + sq + T_W'(carry);
        r   <= carry ? SW'(r_sum - {1'b0, span}) : SW'(r_sum);
      end
    end
  end

  assign req.valid   = busy;
  assign req.last    = last;
  assign req.t       = q;
  assign req.quad    = quad;
  assign status.busy = busy;
  assign status.last = last;
endmodule

>>> rtl/cbz_weights.sv
// Bernstein weight stages: squares, then cubes, carrying the quad along.
module cbz_weights import cbz_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  tval_t       t,
  input  quad_t       quad_in,
  output weight_t [3:0] w,
  output quad_t       quad_out
);
  logic [2*T_W-1:0] t2, u2, tu;
  tval_t            ta, ua;
  quad_t            quad_a;
  tval_t            u;
  logic [3*T_W-1:0] p_uuu, p_ttt, p_tuu, p_ttu;

  assign u = T_ONE - t;

  // Stage A: second-order products
  always_ff @(posedge clk) begin
    if (en) begin
      t2     <= t * t;
      u2     <= u * u;
      tu     <= t * u;
      ta     <= t;
      ua     <= u;
      quad_a <= quad_in;
    end
  end

  assign p_uuu = u2 * ua;
  assign p_ttt = t2 * ta;
  assign p_tuu = tu * ua;
  assign p_ttu = tu * ta;

  // Stage B: cubes, inner terms times three
  always_ff @(posedge clk) begin
    if (en) begin
      w[0]     <= WEIGHT_W'(p_uuu);
      w[1]     <= WEIGHT_W'(p_tuu) + WEIGHT_W'({p_tuu, 1'b0});
      w[2]     <= WEIGHT_W'(p_ttu) + WEIGHT_W'({p_ttu, 1'b0});
      w[3]     <= WEIGHT_W'(p_ttt);
      quad_out <= quad_a;
    end
  end
endmodule

>>> rtl/cbz_blend.sv
// One axis: weighted sum of four coordinates, round and saturate.
module cbz_blend import cbz_pkg::*; (
  input  logic          clk,
  input  logic          en,
  input  weight_t [3:0] w,
  input  coord_t  [3:0] p,
  output coord_t        result
);
  localparam int HI_W  = COORD_W + 26;
  localparam int LO_W  = COORD_W + 25;
  localparam int SUM_W = COORD_W + 48 + 4;

  logic signed [HI_W-1:0]  ph [4];
  logic signed [LO_W-1:0]  pl [4];
  logic signed [HI_W+1:0]  hi;
  logic signed [LO_W+1:0]  lo;
  logic signed [SUM_W-1:0] total;
  logic signed [SUM_W-49:0] rounded;

  // Stage C: split products against the high and low weight halves
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        ph[k] <= $signed(p[k]) * $signed({1'b0, w[k][48:24]});
        pl[k] <= $signed(p[k]) * $signed({1'b0, w[k][23:0]});
      end
    end
  end

  // Stage D: sum each half
  always_ff @(posedge clk) begin
    if (en) begin
      hi <= (HI_W+2)'(ph[0]) + (HI_W+2)'(ph[1]) + (HI_W+2)'(ph[2]) + (HI_W+2)'(ph[3]);
      lo <= (LO_W+2)'(pl[0]) + (LO_W+2)'(pl[1]) + (LO_W+2)'(pl[2]) + (LO_W+2)'(pl[3]);
    end
  end

  // Stage E: recombine, round half up at 2^48, clamp
  always_comb begin
    total = (SUM_W'(hi) <<< 24) + SUM_W'(lo) + (SUM_W'(1) <<< 47);
    rounded = total[SUM_W-1:48];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (rounded > 28'sd8388607) result <= 24'h7FFFFF;
      else if (rounded < -28'sd8388608) result <= 24'h800000;
      else result <= rounded[COORD_W-1:0];
    end
  end
endmodule

>>> rtl/cubic_bezier_point_generator_top.sv
// Top level of the cubic Bezier point generator.
//
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  in      | in_valid, in_stall, p0..p3 x/y   | item in
//  out     | out_valid, out_stall, curve_x/y, | point out
//          | last_point                       |
//  cfg     | cfg_wen, cfg_wdata               | write only
//
// One curve point leaves per cycle unless out_stall holds the pipeline; a segment
// issues N points in the sequencer, N = clamped points_per_segment (2..MAX_POINTS),
// so the next quad transfers on the cycle its predecessor issues its last point.
// Points reach the output through two weight stages and three blend stages.
// Reset is synchronous and clears the sequencer and the valid bits.
// out_stall freezes the whole pipeline, the sequencer included, while out_valid is high.
module cubic_bezier_point_generator_top import cbz_pkg::*; #(
  parameter int MAX_POINTS = DEF_MAX_POINTS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wen,
  input  logic [CNT_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_stall,
  input  coord_t           p0_x,
  input  coord_t           p0_y,
  input  coord_t           c1_x,
  input  coord_t           c1_y,
  input  coord_t           c2_x,
  input  coord_t           c2_y,
  input  coord_t           p3_x,
  input  coord_t           p3_y,
  output logic             out_valid,
  input  logic             out_stall,
  output coord_t           curve_x,
  output coord_t           curve_y,
  output logic             last_point
);
`include "cubic_bezier_point_generator_top_macros.svh"

  logic          pipe_en;
  logic          load;
  quad_t         quad_in;
  point_req_t    req;
  seq_status_t   seq_st;
  weight_t [3:0] w;
  quad_t         quad_w;
  logic [4:0]    vld;
  logic [4:0]    lst;

  assign pipe_en  = !vld[4] || !out_stall;
  assign in_stall = seq_st.busy && !(pipe_en && seq_st.last);
  assign load     = in_valid && !in_stall;

  assign quad_in.x = {p3_x, c2_x, c1_x, p0_x};
  assign quad_in.y = {p3_y, c2_y, c1_y, p0_y};

  cbz_seq #(.MAX_POINTS(MAX_POINTS)) u_seq (
    .clk(clk), .rst(rst), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .load(load), .quad_in(quad_in), .en(pipe_en), .req(req), .status(seq_st)
  );

  cbz_weights u_weights (
    .clk(clk), .en(pipe_en), .t(req.t), .quad_in(req.quad),
    .w(w), .quad_out(quad_w)
  );

  cbz_blend u_blend_x (
    .clk(clk), .en(pipe_en), .w(w), .p(quad_w.x), .result(curve_x)
  );

  cbz_blend u_blend_y (
    .clk(clk), .en(pipe_en), .w(w), .p(quad_w.y), .result(curve_y)
  );

  // Advance valid and last flags alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (pipe_en) begin
      vld <= {vld[3:0], req.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) lst <= {lst[3:0], req.last};
  end

  assign out_valid  = vld[4];
  assign last_point = lst[4];

  `CBZ_ASSERT_IMPL(a_load_only_free, clk, rst, load && seq_st.busy, seq_st.last && pipe_en)
  `CBZ_ASSERT_NEXT(a_stall_holds_seq, clk, rst, seq_st.busy && !pipe_en, seq_st.busy)
  `CBZ_ASSERT_NEXT(a_stall_holds_out, clk, rst, vld[4] && out_stall, vld[4] && $stable(lst[4]))
endmodule

>>> tb/sv/tb_cubic_bezier_point_generator_top.sv
// Testbench for the cubic Bezier point generator: directed and random segments, scoreboard.
module tb_cubic_bezier_point_generator_top import cbz_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXP      = DEF_MAX_POINTS;
  localparam int DRAIN_CYC = 12;

  typedef struct {
    coord_t x;
    coord_t y;
    logic   last;
  } curve_pt_t;

  logic             clk;
  logic             rst;
  logic             cfg_wen;
  logic [CNT_W-1:0] cfg_wdata;
  logic             in_valid;
  logic             in_stall;
  coord_t           pin [8];
  logic             out_valid;
  logic             out_stall;
  coord_t           curve_x;
  coord_t           curve_y;
  logic             last_point;

  curve_pt_t        pending_pts[$];
  logic [CNT_W-1:0] seg_points;
  int               mismatch_count;
  int               burst_left;
  bit               sender_steady;
  bit               hold_on = 1'b0;
  event             hold_go;
  int               stall_mode;
  coord_t           last_end_x;
  coord_t           last_end_y;

  cubic_bezier_point_generator_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .p0_x       (pin[0]),
    .p0_y       (pin[1]),
    .c1_x       (pin[2]),
    .c1_y       (pin[3]),
    .c2_x       (pin[4]),
    .c2_y       (pin[5]),
    .p3_x       (pin[6]),
    .p3_y       (pin[7]),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .curve_x    (curve_x),
    .curve_y    (curve_y),
    .last_point (last_point)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12.0 * 2000000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Hold the receiver off for a long stretch on request.
  initial begin
    forever begin
      @(hold_go);
      hold_on <= 1'b1;
      repeat (400) @(posedge clk);
      hold_on <= 1'b0;
    end
  end

  // Weighted sum of four control coordinates, rounded at 2^48 and clamped.
  function automatic coord_t bernstein_blend(coord_t a, coord_t b, coord_t c, coord_t d,
                                             longint unsigned w0, longint unsigned w1,
                                             longint unsigned w2, longint unsigned w3);
    logic signed [89:0] sum;
    logic signed [89:0] rnd;
    sum = $signed(a) * $signed({1'b0, w0}) + $signed(b) * $signed({1'b0, w1})
        + $signed(c) * $signed({1'b0, w2}) + $signed(d) * $signed({1'b0, w3});
    rnd = (sum + (90'sd1 <<< 47)) >>> 48;
    if (rnd > 90'sd8388607) return 24'h7FFFFF;
    if (rnd < -90'sd8388608) return 24'h800000;
    return rnd[23:0];
  endfunction

  // Push the expected curve points of one accepted segment.
  task automatic predict_segment(coord_t q [8]);
    int n;
    longint unsigned t, u;
    curve_pt_t pt;
    n = seg_points;
    if (n < 2) n = 2;
    if (n > MAXP) n = MAXP;
    for (int i = 0; i < n; i++) begin
      t = (longint'(i) * 65536) / (n - 1);
      u = 65536 - t;
      pt.x = bernstein_blend(q[0], q[2], q[4], q[6], u*u*u, 3*t*u*u, 3*t*t*u, t*t*t);
      pt.y = bernstein_blend(q[1], q[3], q[5], q[7], u*u*u, 3*t*u*u, 3*t*t*u, t*t*t);
      pt.last = (i == n - 1);
      pending_pts.push_back(pt);
    end
  endtask

  task automatic report_mismatch(string what, int got, int want);
    mismatch_count++;
    $display("error at %0t: %s got %0h want %0h", $realtime, what, got, want);
  endtask

  // Check each output transfer and drive the stall pattern.
  always @(posedge clk) begin
    curve_pt_t exp_pt;
    if (!rst && out_valid && !out_stall) begin
      if (pending_pts.size() == 0) begin
        report_mismatch("unexpected point", curve_x, 0);
      end else begin
        exp_pt = pending_pts.pop_front();
        if (curve_x !== exp_pt.x) report_mismatch("curve_x", curve_x, exp_pt.x);
        if (curve_y !== exp_pt.y) report_mismatch("curve_y", curve_y, exp_pt.y);
        if (last_point !== exp_pt.last) report_mismatch("last_point", last_point, exp_pt.last);
      end
    end
    if (hold_on) begin
      out_stall <= 1'b1;
    end else begin
      if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 9) == 0);
        2: out_stall <= ($urandom_range(0, 2) == 0);
        default: out_stall <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  // Offer one segment, with burst gaps when not steady, and hold it until it transfers.
  task automatic send_segment(coord_t q [8]);
    if (!sender_steady) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        burst_left = $urandom_range(1, 10);
      end
      burst_left--;
    end
    in_valid <= 1'b1;
    for (int k = 0; k < 8; k++) pin[k] <= q[k];
    do @(posedge clk); while (in_stall);
    predict_segment(q);
    last_end_x = q[6];
    last_end_y = q[7];
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_pts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_point_count(logic [CNT_W-1:0] value);
    wait_drained();
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    seg_points = value;
    cfg_wen <= 1'b0;
  endtask

  function automatic coord_t pick_coord();
    case ($urandom_range(0, 5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return coord_t'($urandom_range(0, 4095)) - 24'd2048;
      default: return coord_t'($urandom);
    endcase
  endfunction

  task automatic send_all(coord_t v);
    coord_t q [8];
    for (int k = 0; k < 8; k++) q[k] = v;
    send_segment(q);
  endtask

  // Extremes of every field, default point count.
  task automatic test_directed_extremes();
    coord_t q [8];
    send_all(24'h7FFFFF);
    send_all(24'h800000);
    send_all(24'h000000);
    send_all(24'hFFFFFF);
    q = '{24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h800000,
          24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h800000};
    send_segment(q);
    q = '{24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF,
          24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF};
    send_segment(q);
    q = '{24'h000001, 24'hFFFFFF, 24'h000100, 24'hFFFF00,
          24'h555555, 24'hAAAAAA, 24'h123456, 24'hEDCBA9};
    send_segment(q);
  endtask

  // Point counts below, at and above the legal range.
  task automatic test_count_clamps();
    logic [CNT_W-1:0] counts [7];
    coord_t q [8];
    counts = '{7'd0, 7'd1, 7'd2, 7'd3, 7'd64, 7'd65, 7'd127};
    foreach (counts[j]) begin
      write_point_count(counts[j]);
      for (int k = 0; k < 8; k++) q[k] = pick_coord();
      send_segment(q);
      send_segment(q);
    end
  endtask

  // Long receiver hold-off while segments keep arriving, then a full pause.
  task automatic test_backpressure();
    coord_t q [8];
    write_point_count(7'd8);
    -> hold_go;
    sender_steady = 1'b1;
    repeat (6) begin
      for (int k = 0; k < 8; k++) q[k] = pick_coord();
      send_segment(q);
    end
    sender_steady = 1'b0;
    wait_drained();
  endtask

  // Mostly chained segments with random content, some loose ones.
  task automatic test_random_chains();
    coord_t q [8];
    for (int n = 0; n < 132; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 3))
          0: write_point_count(CNT_W'($urandom_range(2, 6)));
          1: write_point_count(CNT_W'($urandom_range(0, 127)));
          2: write_point_count(7'd64);
          default: write_point_count(CNT_W'($urandom_range(2, 16)));
        endcase
      end
      if (n % 23 == 0) sender_steady = !sender_steady;
      for (int k = 0; k < 8; k++) q[k] = pick_coord();
      if ($urandom_range(0, 3) != 0) begin
        q[0] = last_end_x;
        q[1] = last_end_y;
      end
      send_segment(q);
    end
    sender_steady = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    cfg_wen = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    out_stall = 1'b0;
    for (int k = 0; k < 8; k++) pin[k] = '0;
    seg_points = PPS_RESET;
    mismatch_count = 0;
    burst_left = 0;
    sender_steady = 1'b0;
    stall_mode = 0;
    last_end_x = '0;
    last_end_y = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_extremes();
    test_count_clamps();
    test_backpressure();
    test_random_chains();

    wait_drained();
    if (mismatch_count == 0 && pending_pts.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

>>> cubic_bezier_point_generator_top.f
+incdir+rtl
rtl/cbz_pkg.sv
rtl/cbz_seq.sv
rtl/cbz_weights.sv
rtl/cbz_blend.sv
rtl/cubic_bezier_point_generator_top.sv
tb/sv/tb_cubic_bezier_point_generator_top.sv
